### sv/mbtas_pkg.sv
package mbtas_pkg;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_SUB = 1'b1;

   localparam logic [3:0] DEC_BASE = 4'd10;
   localparam logic [3:0] SEX_BASE = 4'd6;

   typedef struct packed {
      logic       kind;
      logic       channel;
      logic [6:0] amount;
   } req_type;

   typedef struct packed {
      logic [3:0] tenths_digit;
      logic [3:0] seconds_ones;
      logic [2:0] seconds_tens;
      logic [3:0] minutes_ones;
      logic [3:0] minutes_tens;
      logic       at_zero;
      logic       at_full;
   } rsp_type;

   typedef struct packed {
      logic [3:0] m10;
      logic [3:0] m1;
      logic [2:0] s10;
      logic [3:0] s1;
      logic [3:0] t;
   } bcd_time_type;

   localparam bcd_time_type TIME_MAX = '{m10: 4'd9, m1: 4'd9, s10: 3'd5, s1: 4'd9, t: 4'd9};

   typedef struct packed {
      logic accept;
      logic calc;
      logic commit;
   } cmd_type;

endpackage

### sv/mbtas_ctrl.sv
module mbtas_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output mbtas_pkg::cmd_type cmd
);
   import mbtas_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_CALC   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CALC;
         end
         ST_CALC:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.accept = start && (state_ff == ST_IDLE);
   assign cmd.calc   = (state_ff == ST_CALC);
   assign cmd.commit = (state_ff == ST_COMMIT);

endmodule

### sv/mbtas_dpath.sv
module mbtas_dpath #(
   parameter int CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  mbtas_pkg::cmd_type cmd,
   input  mbtas_pkg::req_type req_data,
   output mbtas_pkg::rsp_type rsp_data
);
   import mbtas_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   bcd_time_type          bank_ff [CHANNELS];
   logic [CHANNELS-1:0]   zero_ff;
   logic [CHANNELS-1:0]   full_ff;

   logic                  kind_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  inrange_ff;
   bcd_time_type          cur_ff;
   logic                  curz_ff;
   logic                  curf_ff;
   logic [3:0]            adt_ff;
   logic [3:0]            ads1_ff;
   logic                  ads10_ff;

   bcd_time_type          res_ff;
   logic                  resz_ff;
   logic                  resf_ff;

   logic [IDX_W-1:0]      idx_in;
   logic                  inrange_in;
   logic [14:0]           prod;
   logic [3:0]            tens;
   logic [3:0]            adt_in;
   logic [3:0]            ads1_in;
   logic                  ads10_in;

   bcd_time_type          sum;
   bcd_time_type          dif;
   logic                  ovf;
   logic                  unf;
   logic [4:0]            a0, a1, a2, a3, a4;
   logic [4:0]            b0, b1, b2, b3, b4;
   bcd_time_type          res_in;
   logic                  resz_in;
   logic                  resf_in;

   function automatic logic [4:0] digit_add(input logic [3:0] a, input logic [3:0] b,
                                            input logic ci, input logic [3:0] base);
      logic [4:0] s;
      s = {1'b0, a} + {1'b0, b} + {4'b0, ci};
      if (s >= {1'b0, base}) digit_add = {1'b1, 4'(s - {1'b0, base})};
      else                   digit_add = {1'b0, s[3:0]};
   endfunction

   function automatic logic [4:0] digit_sub(input logic [3:0] a, input logic [3:0] b,
                                            input logic bi, input logic [3:0] base);
      logic [4:0] s;
      logic       br;
      s  = {1'b0, a} - {1'b0, b} - {4'b0, bi};
      br = ({1'b0, a} < ({1'b0, b} + {4'b0, bi}));
      if (br) digit_sub = {1'b1, 4'(s[3:0] + base)};
      else    digit_sub = {1'b0, s[3:0]};
   endfunction

   // amount to digits: divide by ten via reciprocal, exact for every 7-bit amount
   always_comb begin
      idx_in     = IDX_W'(req_data.channel);
      inrange_in = (32'(req_data.channel) < CHANNELS);
      prod       = 15'(req_data.amount) * 15'd205;
      tens       = prod[14:11];
      adt_in     = 4'(req_data.amount - 7'(tens) * 7'd10);
      ads10_in   = (tens >= DEC_BASE);
      ads1_in    = ads10_in ? 4'(tens - DEC_BASE) : tens;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= req_data.kind;
         idx_ff     <= idx_in;
         inrange_ff <= inrange_in;
         cur_ff     <= inrange_in ? bank_ff[idx_in] : '0;
         curz_ff    <= inrange_in ? zero_ff[idx_in] : 1'b0;
         curf_ff    <= inrange_in ? full_ff[idx_in] : 1'b0;
         adt_ff     <= adt_in;
         ads1_ff    <= ads1_in;
         ads10_ff   <= ads10_in;
      end
   end

   always_comb begin
      a0 = digit_add(cur_ff.t,  adt_ff,  1'b0, DEC_BASE);
      a1 = digit_add(cur_ff.s1, ads1_ff, a0[4], DEC_BASE);
      a2 = digit_add({1'b0, cur_ff.s10}, {3'b0, ads10_ff}, a1[4], SEX_BASE);
      a3 = digit_add(cur_ff.m1,  4'd0, a2[4], DEC_BASE);
      a4 = digit_add(cur_ff.m10, 4'd0, a3[4], DEC_BASE);
      sum = '{m10: a4[3:0], m1: a3[3:0], s10: a2[2:0], s1: a1[3:0], t: a0[3:0]};
      ovf = a4[4];

      b0 = digit_sub(cur_ff.t,  adt_ff,  1'b0, DEC_BASE);
      b1 = digit_sub(cur_ff.s1, ads1_ff, b0[4], DEC_BASE);
      b2 = digit_sub({1'b0, cur_ff.s10}, {3'b0, ads10_ff}, b1[4], SEX_BASE);
      b3 = digit_sub(cur_ff.m1,  4'd0, b2[4], DEC_BASE);
      b4 = digit_sub(cur_ff.m10, 4'd0, b3[4], DEC_BASE);
      dif = '{m10: b4[3:0], m1: b3[3:0], s10: b2[2:0], s1: b1[3:0], t: b0[3:0]};
      unf = b4[4];

      res_in  = cur_ff;
      resz_in = curz_ff;
      resf_in = curf_ff;
      if (!inrange_ff) begin
         res_in  = '0;
         resz_in = 1'b0;
         resf_in = 1'b0;
      end else if (kind_ff == KIND_ADD) begin
         if (!curf_ff) begin
            resz_in = 1'b0;
            if (ovf) begin
               res_in  = TIME_MAX;
               resf_in = 1'b1;
            end else begin
               res_in  = sum;
            end
         end
      end else begin
         if (!curz_ff) begin
            resf_in = 1'b0;
            if (unf) begin
               res_in  = '0;
               resz_in = 1'b1;
            end else begin
               res_in  = dif;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         res_ff  <= res_in;
         resz_ff <= resz_in;
         resf_ff <= resf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) bank_ff[i] <= '0;
         zero_ff <= '0;
         full_ff <= '0;
      end else if (cmd.commit && inrange_ff) begin
         bank_ff[idx_ff] <= res_ff;
         zero_ff[idx_ff] <= resz_ff;
         full_ff[idx_ff] <= resf_ff;
      end
   end

   assign rsp_data.tenths_digit = res_ff.t;
   assign rsp_data.seconds_ones = res_ff.s1;
   assign rsp_data.seconds_tens = res_ff.s10;
   assign rsp_data.minutes_ones = res_ff.m1;
   assign rsp_data.minutes_tens = res_ff.m10;
   assign rsp_data.at_zero      = resz_ff;
   assign rsp_data.at_full      = resf_ff;

endmodule

### sv/multichannel_bcd_time_add_sub_unit.sv
// Multichannel decimal time counter, display form mm:ss.t, one per channel.
// Request side: raise start with req_data (kind, channel, amount in tenths);
// the transaction is taken at a rising edge where start is high and busy is low.
// Busy stays high while the transaction is worked on.
// Response side: rsp_strobe is high for exactly one cycle with rsp_data holding
// the channel's five digits and its zero and full flags after the operation.
// Timing: after the accepting edge the controller steps through its compute and
// write-back states, and rsp_strobe is high in the write-back state. No new
// transaction is accepted until the controller is idle again, so the accept, compute
// and write-back sequence over the channel's stored state finishes before the next.
// Adds saturate at 99:59.9 and set full; while full, adds are ignored.
// Subtracts saturate at 00:00.0 and set zero; while zero, subtracts are ignored.
// A channel number beyond the configured count changes nothing and returns zeros.
// Reset (synchronous, active high) clears every channel to 00:00.0 with both
// flags clear and returns the controller to idle.
// The receiver cannot stall: each response must be taken in its strobe cycle.
module multichannel_bcd_time_add_sub_unit #(
   parameter int CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mbtas_pkg::req_type req_data,
   output logic               rsp_strobe,
   output mbtas_pkg::rsp_type rsp_data
);
   import mbtas_pkg::*;

   cmd_type cmd;

   mbtas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   mbtas_dpath #(
      .CHANNELS (CHANNELS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   assign rsp_strobe = cmd.commit;

endmodule

### dv/multichannel_bcd_time_add_sub_unit_test.sv
`timescale 1ns / 100ps

module multichannel_bcd_time_add_sub_unit_test;
   import mbtas_pkg::*;

   localparam int          CHANNEL_COUNT     = 2;
   localparam int unsigned TIME_CEILING      = 59999;
   localparam int unsigned CYCLE_LIMIT       = 500000;
   localparam int unsigned DRAIN_CYCLES      = 10;
   localparam int          CLIMB_ITEMS       = 700;
   localparam int          WANDER_ITEMS      = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type     pending_items[$];
   rsp_type     expected_times[$];
   int unsigned chan_tenths[CHANNEL_COUNT];
   logic        chan_zero[CHANNEL_COUNT];
   logic        chan_full[CHANNEL_COUNT];
   int unsigned idle_left = 0;
   int unsigned steady_left = 0;
   int unsigned items_taken = 0;
   int unsigned items_total = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   multichannel_bcd_time_add_sub_unit #(
      .CHANNELS(CHANNEL_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_type apply_time_step(req_type item);
      rsp_type     result;
      int unsigned ch;
      int unsigned v;
      int unsigned sec;
      int unsigned mins;
      result = '0;
      ch = 32'(item.channel);
      if (ch >= CHANNEL_COUNT) return result;
      v = chan_tenths[ch];
      if (item.kind == KIND_ADD) begin
         if (!chan_full[ch]) begin
            chan_zero[ch] = 1'b0;
            v = v + item.amount;
            if (v > TIME_CEILING) begin
               v = TIME_CEILING;
               chan_full[ch] = 1'b1;
            end
         end
      end else begin
         if (!chan_zero[ch]) begin
            chan_full[ch] = 1'b0;
            if (item.amount > v) begin
               v = 0;
               chan_zero[ch] = 1'b1;
            end else begin
               v = v - item.amount;
            end
         end
      end
      chan_tenths[ch] = v;
      sec = (v / 10) % 60;
      mins = v / 600;
      result.tenths_digit = 4'(v % 10);
      result.seconds_ones = 4'(sec % 10);
      result.seconds_tens = 3'(sec / 10);
      result.minutes_ones = 4'(mins % 10);
      result.minutes_tens = 4'(mins / 10);
      result.at_zero = chan_zero[ch];
      result.at_full = chan_full[ch];
      return result;
   endfunction

   function automatic int unsigned next_gap();
      int unsigned r;
      if (steady_left != 0) begin
         steady_left = steady_left - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic queue_item(input logic kind, input logic ch, input int unsigned amount);
      req_type item;
      item.kind = kind;
      item.channel = ch;
      item.amount = 7'(amount);
      pending_items.push_back(item);
   endtask

   task automatic report_mismatch(input string field, input logic [3:0] got,
                                  input logic [3:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   task automatic check_time_result(input rsp_type got, input rsp_type want);
      if (got.tenths_digit !== want.tenths_digit)
         report_mismatch("tenths_digit", got.tenths_digit, want.tenths_digit);
      if (got.seconds_ones !== want.seconds_ones)
         report_mismatch("seconds_ones", got.seconds_ones, want.seconds_ones);
      if (got.seconds_tens !== want.seconds_tens)
         report_mismatch("seconds_tens", 4'(got.seconds_tens), 4'(want.seconds_tens));
      if (got.minutes_ones !== want.minutes_ones)
         report_mismatch("minutes_ones", got.minutes_ones, want.minutes_ones);
      if (got.minutes_tens !== want.minutes_tens)
         report_mismatch("minutes_tens", got.minutes_tens, want.minutes_tens);
      if (got.at_zero !== want.at_zero)
         report_mismatch("at_zero", 4'(got.at_zero), 4'(want.at_zero));
      if (got.at_full !== want.at_full)
         report_mismatch("at_full", 4'(got.at_full), 4'(want.at_full));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            expected_times.push_back(apply_time_step(req_data));
            items_taken++;
         end
         if (!start || !busy) begin
            if (idle_left != 0) begin
               idle_left <= idle_left - 1;
               start <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data <= pending_items.pop_front();
               start <= 1'b1;
               idle_left <= next_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_times.size() == 0) begin
            $display("unexpected transaction at %0t", $realtime);
            error_count++;
         end else begin
            check_time_result(rsp_data, expected_times.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $realtime);
         $display("FAIL multichannel_bcd_time_add_sub_unit");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      int unsigned amount;
      logic        kind;
      logic        ch;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         chan_tenths[i] = 0;
         chan_zero[i] = 1'b0;
         chan_full[i] = 1'b0;
      end

      // directed: borrows, carries, exact zero and both underflow cases
      queue_item(KIND_SUB, 1'b0, 0);
      queue_item(KIND_SUB, 1'b0, 1);
      queue_item(KIND_SUB, 1'b0, 5);
      queue_item(KIND_ADD, 1'b0, 0);
      queue_item(KIND_ADD, 1'b0, 127);
      queue_item(KIND_ADD, 1'b0, 99);
      queue_item(KIND_SUB, 1'b0, 26);
      queue_item(KIND_ADD, 1'b0, 127);
      queue_item(KIND_ADD, 1'b0, 127);
      queue_item(KIND_ADD, 1'b0, 127);
      queue_item(KIND_ADD, 1'b0, 19);
      queue_item(KIND_SUB, 1'b0, 1);
      queue_item(KIND_ADD, 1'b0, 1);
      queue_item(KIND_SUB, 1'b0, 127);
      queue_item(KIND_SUB, 1'b0, 127);
      queue_item(KIND_SUB, 1'b0, 127);
      queue_item(KIND_SUB, 1'b0, 127);
      queue_item(KIND_SUB, 1'b0, 92);
      queue_item(KIND_SUB, 1'b0, 0);
      queue_item(KIND_ADD, 1'b0, 5);
      queue_item(KIND_SUB, 1'b0, 6);
      queue_item(KIND_ADD, 1'b0, 0);
      queue_item(KIND_ADD, 1'b1, 127);
      queue_item(KIND_SUB, 1'b1, 64);

      // climb channel 1 to the top while channel 0 wanders
      for (int i = 0; i < CLIMB_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            ch = 1'b1;
            kind = ($urandom_range(0, 99) < 97) ? KIND_ADD : KIND_SUB;
            amount = $urandom_range(100, 127);
         end else begin
            ch = 1'b0;
            kind = 1'($urandom_range(0, 1));
            amount = $urandom_range(0, 127);
         end
         queue_item(kind, ch, amount);
      end

      // free mix around both saturation points
      for (int i = 0; i < WANDER_ITEMS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 70) amount = $urandom_range(0, 99);
         else if (r < 85) amount = $urandom_range(100, 127);
         else amount = $urandom_range(0, 3);
         queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), amount);
      end
      items_total = pending_items.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < items_total) @(posedge clock);
      while (expected_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS multichannel_bcd_time_add_sub_unit");
      end else begin
         $display("FAIL multichannel_bcd_time_add_sub_unit");
      end
      $finish;
   end

endmodule
